// ===== rtl/core/pcpd_pkg.sv =====
// pcpd_pkg: widths, register indexes and controller/datapath interface types
// for the phase-code pulse decoder. No dependencies.

package pcpd_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int CH_W      = 2;
	localparam int PULSE_W   = 4;
	localparam int GATE_W    = 10;
	localparam int DEC_W     = 25;
	localparam int CNT_W     = 11;
	localparam int BAUD_W    = 5;
	localparam int RANGE_W   = 11;
	localparam int CODE_W    = 64;
	localparam int CODE_REGS = 4;
	localparam int ROW_BITS  = 16;
	localparam int ROW_IDX_W = 4;
	localparam int ACC_W     = 21;
	localparam int Q_SHIFT   = 8;
	localparam int DIVD_W    = ACC_W + Q_SHIFT;
	localparam int REM_W     = 5;
	localparam int DSTEP_W   = 5;
	localparam int RLIM_W    = 13;
	localparam int CFG_IDX_W = 3;
	localparam int IN_USER_W  = CH_W + PULSE_W + 1;
	localparam int OUT_DATA_W = 40;
	localparam int OUT_USER_W = CH_W + PULSE_W;

	localparam logic [CNT_W-1:0] COUNT_MAX = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BAUD   = 3'd0,
		REG_RANGE  = 3'd1,
		REG_CODE_A = 3'd2,
		REG_CODE_B = 3'd3,
		REG_CODE_C = 3'd4,
		REG_CODE_D = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [BAUD_W-1:0]                  baud;
		logic [RANGE_W-1:0]                 range;
		logic [CODE_REGS-1:0][CODE_W-1:0]   code;
	} cfg_t;

	typedef struct packed {
		logic take;
		logic wr;
		logic rd;
		logic div_start;
		logic div_step;
		logic load;
	} cmd_t;

	typedef struct packed {
		logic produce;
		logic rd_last;
		logic div_last;
		logic out_free;
	} stat_t;

endpackage

// ===== rtl/core/pcpd_ram.sv =====
// pcpd_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.

module pcpd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/core/pcpd_regs.sv =====
// pcpd_regs: configuration register file (baud count, range count, code rows).
// Depends on pcpd_pkg.

module pcpd_regs import pcpd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CODE_W-1:0]    cfg_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.baud  <= BAUD_W'(1);
			cfg_q.range <= RANGE_W'(75);
			cfg_q.code  <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_BAUD:   cfg_q.baud    <= cfg_data[BAUD_W-1:0];
				REG_RANGE:  cfg_q.range   <= cfg_data[RANGE_W-1:0];
				REG_CODE_A: cfg_q.code[0] <= cfg_data;
				REG_CODE_B: cfg_q.code[1] <= cfg_data;
				REG_CODE_C: cfg_q.code[2] <= cfg_data;
				REG_CODE_D: cfg_q.code[3] <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

// ===== rtl/core/pcpd_ctrl.sv =====
// pcpd_ctrl: sequencer for one word: write, correlate, divide, load output.
// Depends on pcpd_pkg.

module pcpd_ctrl import pcpd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  s_tvalid,
	output logic  s_tready,
	input  stat_t stat,
	output cmd_t  cmd
);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_WRITE = 7'b0000010,
		ST_READ  = 7'b0000100,
		ST_DRAIN = 7'b0001000,
		ST_DIVST = 7'b0010000,
		ST_DIV   = 7'b0100000,
		ST_LOAD  = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (s_tvalid) state_d = ST_WRITE;
			ST_WRITE: state_d = stat.produce ? ST_READ : ST_IDLE;
			ST_READ:  if (stat.rd_last) state_d = ST_DRAIN;
			ST_DRAIN: state_d = ST_DIVST;
			ST_DIVST: state_d = ST_DIV;
			ST_DIV:   if (stat.div_last) state_d = ST_LOAD;
			ST_LOAD:  if (stat.out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign s_tready      = (state_q == ST_IDLE);
	assign cmd.take      = (state_q == ST_IDLE) && s_tvalid;
	assign cmd.wr        = (state_q == ST_WRITE);
	assign cmd.rd        = (state_q == ST_READ);
	assign cmd.div_start = (state_q == ST_DIVST);
	assign cmd.div_step  = (state_q == ST_DIV);
	assign cmd.load      = (state_q == ST_LOAD) && stat.out_free;

endmodule

// ===== rtl/core/pcpd_datapath.sv =====
// pcpd_datapath: per-channel circular delay lines, counters, correlator,
// restoring divider and output register. Depends on pcpd_pkg, pcpd_ram.

module pcpd_datapath import pcpd_pkg::*; #(
	parameter int MAX_BAUD        = 16,
	parameter int MAX_PULSES      = 16,
	parameter int CHANNELS        = 4,
	parameter int MAX_RANGE_GATES = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfg_t                  cfg,
	input  cmd_t                  cmd,
	output stat_t                 stat,
	input  logic [SAMPLE_W-1:0]   s_tdata,
	input  logic [IN_USER_W-1:0]  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic [OUT_USER_W-1:0] m_tuser
);

	localparam int PTR_W    = (MAX_BAUD > 1) ? $clog2(MAX_BAUD) : 1;
	localparam int CW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int RAM_AW   = CW + PTR_W;
	localparam int RAM_D    = 2 ** RAM_AW;
	localparam int BAUD_LIM = (MAX_BAUD < ROW_BITS) ? MAX_BAUD : ROW_BITS;

	// latched word
	logic [SAMPLE_W-1:0] smp_q;
	logic [CH_W-1:0]     ch_q;
	logic [PULSE_W-1:0]  pl_q;
	logic                start_q;

	logic [CNT_W-1:0] cnt_q  [CHANNELS];
	logic [PTR_W-1:0] head_q [CHANNELS];

	logic [PTR_W-1:0]     wr_ptr_q;
	logic [GATE_W-1:0]    gate_q;
	logic [ROW_BITS-1:0]  row_q;
	logic [ROW_IDX_W-1:0] i_q;
	logic [ROW_IDX_W-1:0] i_s1;
	logic                 rd_s1;
	logic signed [ACC_W-1:0] acc_q;

	logic [DIVD_W-1:0]  dq_q;
	logic [REM_W-1:0]   rem_q;
	logic               neg_q;
	logic [DSTEP_W-1:0] dcnt_q;

	logic                out_valid_q;
	logic [DEC_W-1:0]    dec_o_q;
	logic [GATE_W-1:0]   gate_o_q;
	logic [CH_W-1:0]     ch_o_q;
	logic [PULSE_W-1:0]  pl_o_q;

	logic [CW-1:0]      ch_idx;
	logic               item_ok;
	logic [CNT_W-1:0]   cnt_base, cnt_new, gate;
	logic [BAUD_W-1:0]  nb, age;
	logic [RLIM_W-1:0]  range_ext, rlim;
	logic [PTR_W-1:0]   head_new, rd_ptr;
	logic [CODE_W-1:0]  code_reg;
	logic [ROW_BITS-1:0] row;
	logic [SAMPLE_W-1:0] rd_data;
	logic signed [ACC_W-1:0] smp_ext;
	logic [ACC_W-1:0]   mag;
	logic [REM_W:0]     trial;
	logic               ge;
	logic [DIVD_W-1:0]  q_signed;

	assign ch_idx  = CW'(ch_q);
	assign item_ok = (32'(ch_q) < CHANNELS) && (32'(pl_q) < MAX_PULSES);

	always_comb begin
		if (cfg.baud == '0) begin
			nb = BAUD_W'(1);
		end else if (cfg.baud > BAUD_W'(BAUD_LIM)) begin
			nb = BAUD_W'(BAUD_LIM);
		end else begin
			nb = cfg.baud;
		end
		range_ext = RLIM_W'(cfg.range);
		rlim = (range_ext > RLIM_W'(MAX_RANGE_GATES)) ? RLIM_W'(MAX_RANGE_GATES) : range_ext;
	end

	assign cnt_base = start_q ? '0 : cnt_q[ch_idx];
	assign cnt_new  = (cnt_base == COUNT_MAX) ? cnt_base : cnt_base + CNT_W'(1);
	assign gate     = cnt_new - CNT_W'(nb);
	assign head_new = head_q[ch_idx] + PTR_W'(1);

	assign code_reg = cfg.code[pl_q[3:2]];
	assign row      = code_reg[{pl_q[1:0], 4'd0} +: ROW_BITS];

	// oldest sample of the window first
	assign age    = nb - BAUD_W'(1) - BAUD_W'(i_q);
	assign rd_ptr = wr_ptr_q - PTR_W'(age);

	assign stat.produce  = item_ok && (cnt_new >= CNT_W'(nb)) && (RLIM_W'(gate) < rlim);
	assign stat.rd_last  = (BAUD_W'(i_q) == nb - BAUD_W'(1));
	assign stat.div_last = (dcnt_q == DSTEP_W'(DIVD_W - 1));
	assign stat.out_free = !out_valid_q || m_tready;

	pcpd_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(RAM_D)
	) u_line (
		.clk  (clk),
		.we   (cmd.wr && item_ok),
		.waddr({ch_idx, head_new}),
		.wdata(smp_q),
		.raddr({ch_idx, rd_ptr}),
		.rdata(rd_data)
	);

	assign smp_ext  = ACC_W'($signed(rd_data));
	assign mag      = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
	assign trial    = {rem_q, dq_q[DIVD_W-1]};
	assign ge       = (trial >= {1'b0, nb});
	assign q_signed = neg_q ? (~dq_q + DIVD_W'(1)) : dq_q;

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			smp_q   <= s_tdata;
			ch_q    <= s_tuser[CH_W-1:0];
			pl_q    <= s_tuser[CH_W +: PULSE_W];
			start_q <= s_tuser[CH_W + PULSE_W];
		end
		if (cmd.wr) begin
			wr_ptr_q <= head_new;
			gate_q   <= gate[GATE_W-1:0];
			row_q    <= row;
			i_q      <= '0;
			acc_q    <= '0;
		end
		if (cmd.rd) begin
			i_q <= i_q + ROW_IDX_W'(1);
		end
		i_s1 <= i_q;
		if (rd_s1) begin
			acc_q <= row_q[i_s1] ? acc_q + smp_ext : acc_q - smp_ext;
		end
		if (cmd.div_start) begin
			dq_q   <= {mag, {Q_SHIFT{1'b0}}};
			rem_q  <= '0;
			neg_q  <= acc_q[ACC_W-1];
			dcnt_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q  <= ge ? REM_W'(trial - {1'b0, nb}) : trial[REM_W-1:0];
			dq_q   <= {dq_q[DIVD_W-2:0], ge};
			dcnt_q <= dcnt_q + DSTEP_W'(1);
		end
		if (cmd.load) begin
			dec_o_q  <= q_signed[DEC_W-1:0];
			gate_o_q <= gate_q;
			ch_o_q   <= ch_q;
			pl_o_q   <= pl_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				cnt_q[c]  <= '0;
				head_q[c] <= '0;
			end
			rd_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_s1 <= cmd.rd;
			if (cmd.wr) begin
				for (int c = 0; c < CHANNELS; c++) begin
					if (item_ok && (CW'(c) == ch_idx)) begin
						cnt_q[c] <= cnt_new;
					end else if (start_q) begin
						cnt_q[c] <= '0;
					end
				end
				if (item_ok) begin
					head_q[ch_idx] <= head_new;
				end
			end
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_DATA_W - DEC_W - GATE_W){1'b0}}, gate_o_q, dec_o_q};
	assign m_tuser  = {pl_o_q, ch_o_q};

endmodule

// ===== rtl/core/phase_code_pulse_decoder.sv =====
// phase_code_pulse_decoder: top level, binary phase-code range-gate correlator.
// Depends on pcpd_pkg, pcpd_regs, pcpd_ctrl, pcpd_datapath, pcpd_ram.
//
// Input stream s_*: one receiver sample per word, tagged with channel, pulse
// number and a start mark that clears all channel sample counts first.
// Output stream m_*: one decoded range gate, trunc(256 * correlation / nb),
// for each sample once nb samples of its channel have arrived since the last
// start mark, until range_count gates have been sent for that channel.
// Config port cfg_*: register writes by index, always ready, idle use only.
// Timing: a word is taken and written to its channel's delay line in the
// following cycle; a word that makes no gate then frees the input.
// A word that makes a gate goes on with nb reads of the delay-line RAM, one
// per cycle, then a 29-step restoring divider, one quotient bit per cycle,
// then the output register load once that register is free.
// The output register holds a finished gate while the receiver stalls; the
// next sample is taken and processed meanwhile, and its own gate waits for
// the register to free up.
// Reset clears counters, line pointers and the output valid; registers take
// their defaults. The delay-line RAM needs no clearing: a window is only read
// after all of its samples have been written.

module phase_code_pulse_decoder import pcpd_pkg::*; #(
	parameter int MAX_BAUD        = 16,
	parameter int MAX_PULSES      = 16,
	parameter int CHANNELS        = 4,
	parameter int MAX_RANGE_GATES = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [SAMPLE_W-1:0]   s_tdata,   // sample[15:0]
	input  logic [IN_USER_W-1:0]  s_tuser,   // channel[1:0], pulse[5:2], start_req[6]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // decoded[24:0], range_gate[34:25], zero[39:35]
	output logic [OUT_USER_W-1:0] m_tuser,   // out_channel[1:0], out_pulse[5:2]
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CODE_W-1:0]     cfg_data
);

	cfg_t  cfg;
	cmd_t  cmd;
	stat_t stat;

	pcpd_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	pcpd_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	pcpd_datapath #(
		.MAX_BAUD       (MAX_BAUD),
		.MAX_PULSES     (MAX_PULSES),
		.CHANNELS       (CHANNELS),
		.MAX_RANGE_GATES(MAX_RANGE_GATES)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.cmd     (cmd),
		.stat    (stat),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

endmodule

// ===== rtl/core/pcpd_checker.sv =====
// pcpd_checker: port-level assertions for the phase-code pulse decoder,
// bound to the top level. Depends on pcpd_pkg.

module pcpd_checker import pcpd_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,
	input logic [OUT_USER_W-1:0] m_tuser
);

	// stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output word changed while stalled");

	// one word at a time: busy right after a take
	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input ready right after a take");

	// a new gate is only loaded while the sequencer is busy
	a_out_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("output word appeared while idle");

	// quotient stays within the Q8 range of a 16-bit sample
	a_dec_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[DEC_W-1:0]) <= 25'sd8388608) &&
			($signed(m_tdata[DEC_W-1:0]) >= -25'sd8388608))
		else $error("decoded value out of range");

endmodule

bind phase_code_pulse_decoder pcpd_checker u_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);

// ===== tb/tb.sv =====
// tb: self-checking bench for phase_code_pulse_decoder. Streams tagged samples,
// predicts each decoded range gate with an in-bench correlator and compares.
// Depends on pcpd_pkg and the phase_code_pulse_decoder RTL.

module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import pcpd_pkg::*;

	localparam int N_CH         = 4;
	localparam int LINE_DEPTH   = 16;
	localparam int GATE_CAP     = 1024;
	localparam int SETTLE       = 64;
	localparam int STALL_LIMIT  = 4000;
	localparam int RANDOM_WORDS = 200;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

	typedef struct {
		logic signed [DEC_W-1:0] decoded;
		logic [CH_W-1:0]         chan;
		logic [PULSE_W-1:0]      pulse;
		logic [GATE_W-1:0]       gate;
	} gate_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [SAMPLE_W-1:0]   s_tdata;
	logic [IN_USER_W-1:0]  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [OUT_USER_W-1:0] m_tuser;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CODE_W-1:0]     cfg_data;

	// correlator model state
	logic [BAUD_W-1:0]   cfg_baud;
	logic [RANGE_W-1:0]  cfg_range;
	logic [CODE_W-1:0]   cfg_code [CODE_REGS];
	logic [SAMPLE_W-1:0] tap_line [N_CH][LINE_DEPTH];
	logic [CNT_W-1:0]    chan_count [N_CH];

	gate_t gate_queue [$];
	int    errors = 0;
	int    words_sent = 0;
	int    quiet_cycles = 0;
	int    stall_left = 0;
	bit    idle_on;

	phase_code_pulse_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	function automatic bit correlate_word(input logic [SAMPLE_W-1:0] smp,
		input logic [CH_W-1:0] ch, input logic [PULSE_W-1:0] pl, input logic st,
		output gate_t g);
		int nb;
		int rc;
		int gate;
		longint acc;
		longint tap;
		logic [CODE_W-1:0] row;
		g = '{default: '0};
		if (st)
			for (int k = 0; k < N_CH; k++) chan_count[k] = '0;
		for (int i = LINE_DEPTH - 1; i > 0; i--) tap_line[ch][i] = tap_line[ch][i-1];
		tap_line[ch][0] = smp;
		if (chan_count[ch] != COUNT_MAX) chan_count[ch] = chan_count[ch] + 1'b1;
		nb = (cfg_baud == 0) ? 1 : (cfg_baud > LINE_DEPTH) ? LINE_DEPTH : int'(cfg_baud);
		rc = (cfg_range > GATE_CAP) ? GATE_CAP : int'(cfg_range);
		if (int'(chan_count[ch]) < nb) return 1'b0;
		gate = int'(chan_count[ch]) - nb;
		if (gate >= rc) return 1'b0;
		// oldest sample of the window takes code element 0
		row = cfg_code[pl[3:2]];
		acc = 0;
		for (int i = 0; i < nb; i++) begin
			tap = longint'($signed(tap_line[ch][nb-1-i]));
			acc += row[int'(pl[1:0]) * ROW_BITS + i] ? tap : -tap;
		end
		acc = (acc * 256) / nb;
		g.decoded = acc[DEC_W-1:0];
		g.chan = ch;
		g.pulse = pl;
		g.gate = gate[GATE_W-1:0];
		return 1'b1;
	endfunction

	function automatic logic [SAMPLE_W-1:0] rand_sample();
		case ($urandom_range(0, 11))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'h0000;
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	function automatic logic [BAUD_W-1:0] rand_baud();
		case ($urandom_range(0, 9))
			0: return 5'd0;
			1: return BAUD_W'($urandom_range(17, 31));
			2: return 5'd16;
			3: return 5'd1;
			default: return BAUD_W'($urandom_range(1, 16));
		endcase
	endfunction

	function automatic logic [RANGE_W-1:0] rand_range();
		case ($urandom_range(0, 9))
			0: return 11'd0;
			1: return 11'd1024;
			2: return RANGE_W'($urandom_range(1025, 2047));
			3: return 11'd1;
			default: return RANGE_W'($urandom_range(2, 40));
		endcase
	endfunction

	function automatic logic [CODE_W-1:0] rand_code();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic send_word(input logic [SAMPLE_W-1:0] smp, input logic [CH_W-1:0] ch,
		input logic [PULSE_W-1:0] pl, input logic st);
		gate_t g;
		@(negedge clk);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= smp;
		s_tuser <= {st, pl, ch};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (correlate_word(smp, ch, pl, st, g)) gate_queue.push_back(g);
		words_sent++;
	endtask

	task automatic stream_release();
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CODE_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_BAUD: cfg_baud = val[BAUD_W-1:0];
			REG_RANGE: cfg_range = val[RANGE_W-1:0];
			REG_CODE_A, REG_CODE_B, REG_CODE_C, REG_CODE_D: cfg_code[idx - REG_CODE_A] = val;
			default: ;
		endcase
	endtask

	task automatic cfg_release();
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// upper data bits of the size registers carry junk that must be dropped
	task automatic set_config(input logic [BAUD_W-1:0] baud, input logic [RANGE_W-1:0] range,
		input logic [CODE_W-1:0] ca, input logic [CODE_W-1:0] cb,
		input logic [CODE_W-1:0] cc, input logic [CODE_W-1:0] cd);
		logic [CODE_W-1:0] junk;
		junk = {$urandom, $urandom};
		write_reg(REG_BAUD, {junk[CODE_W-1:BAUD_W], baud});
		write_reg(REG_RANGE, {junk[CODE_W-1:RANGE_W], range});
		write_reg(REG_CODE_A, ca);
		write_reg(REG_CODE_B, cb);
		write_reg(REG_CODE_C, cc);
		write_reg(REG_CODE_D, cd);
		cfg_release();
	endtask

	task automatic wait_idle();
		while (gate_queue.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic test_defaults();
		send_word(16'h7fff, 2'd0, 4'd0, 1'b0);
		send_word(16'h8000, 2'd1, 4'd15, 1'b0);
		send_word(16'h0000, 2'd2, 4'd7, 1'b1);
		send_word(16'hffff, 2'd3, 4'd8, 1'b0);
		stream_release();
	endtask

	task automatic test_unknown_index();
		wait_idle();
		write_reg(REG_SPARE_6, '1);
		write_reg(REG_SPARE_7, '1);
		cfg_release();
		send_word(16'h1234, 2'd0, 4'd2, 1'b0);
		stream_release();
	endtask

	// full 16-baud window at negative full scale, mixed pulses, newest pulse row all +1
	task automatic test_full_window();
		wait_idle();
		set_config(5'd16, 11'd1, '0, 64'h0000_0000_ffff_0000, '0, '0);
		for (int n = 0; n < 16; n++)
			send_word(16'h8000, 2'd1, (n == 15) ? 4'd5 : PULSE_W'($urandom), n == 0);
		send_word(16'h8000, 2'd1, 4'd5, 1'b0);
		stream_release();
	endtask

	task automatic test_degenerate_sizes();
		wait_idle();
		set_config(5'd0, 11'd0, rand_code(), rand_code(), rand_code(), rand_code());
		for (int n = 0; n < 3; n++) send_word(rand_sample(), 2'(n), 4'($urandom), n == 0);
		stream_release();
		wait_idle();
		set_config(5'd0, 11'd3, '1, '0, {$urandom, $urandom}, '1);
		for (int n = 0; n < 3; n++) send_word(rand_sample(), 2'd3, 4'($urandom), n == 0);
		stream_release();
	endtask

	// one channel runs past the gate cap, with a start mark only on its first word
	task automatic test_count_saturation();
		logic [CH_W-1:0] ch;
		wait_idle();
		set_config(5'd31, 11'd2047, rand_code(), rand_code(), rand_code(), rand_code());
		for (int n = 0; n < 1060; n++) begin
			ch = (n % 64 == 63) ? CH_W'($urandom) : 2'd2;
			send_word(rand_sample(), ch, PULSE_W'($urandom), n == 0);
		end
		stream_release();
	endtask

	task automatic test_random_records();
		int first_word;
		int phase_words;
		int rec_len;
		logic [PULSE_W-1:0] rec_pulse;
		logic st;
		first_word = words_sent;
		while (words_sent - first_word < RANDOM_WORDS) begin
			if (words_sent - first_word > RANDOM_WORDS - 100) idle_on = 1'b0;
			wait_idle();
			set_config(rand_baud(), rand_range(), rand_code(), rand_code(), rand_code(),
				rand_code());
			phase_words = 0;
			while (phase_words < 100) begin
				rec_len = $urandom_range(4, 60);
				rec_pulse = PULSE_W'($urandom);
				for (int n = 0; n < rec_len; n++) begin
					// mostly clean records, some without a start mark or with a stray one
					st = (n == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 29) == 0);
					send_word(rand_sample(), CH_W'($urandom),
						($urandom_range(0, 9) == 0) ? PULSE_W'($urandom) : rec_pulse, st);
					phase_words++;
				end
			end
			stream_release();
		end
	endtask

	task automatic check_field(input string what, input longint expv, input longint got);
		if (expv != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, expv, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		gate_t exp_g;
		if (arst_n && m_tvalid && m_tready) begin
			if (gate_queue.size() == 0) begin
				$display("%0t: unexpected gate, expected none, actual decoded %0d gate %0d",
					$time, $signed(m_tdata[DEC_W-1:0]), m_tdata[DEC_W +: GATE_W]);
				errors++;
			end else begin
				exp_g = gate_queue.pop_front();
				check_field("decoded", exp_g.decoded, $signed(m_tdata[DEC_W-1:0]));
				check_field("range_gate", exp_g.gate, m_tdata[DEC_W +: GATE_W]);
				check_field("out_channel", exp_g.chan, m_tuser[CH_W-1:0]);
				check_field("out_pulse", exp_g.pulse, m_tuser[CH_W +: PULSE_W]);
			end
		end
	end

	// receiver stalls in bursts
	always @(negedge clk) begin
		if (!idle_on) begin
			m_tready <= 1'b1;
		end else if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else if ($urandom_range(0, 4) == 0) begin
			m_tready <= 1'b0;
			stall_left = $urandom_range(1, 11) - 1;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		idle_on = 1'b1;
		cfg_baud = 5'd1;
		cfg_range = 11'd75;
		for (int k = 0; k < CODE_REGS; k++) cfg_code[k] = '0;
		for (int k = 0; k < N_CH; k++) begin
			chan_count[k] = '0;
			for (int i = 0; i < LINE_DEPTH; i++) tap_line[k][i] = '0;
		end
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_defaults();
		test_unknown_index();
		test_full_window();
		test_degenerate_sizes();
		test_count_saturation();
		test_random_records();
		wait_idle();
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
